[rtl/pps_pkg.sv]
`default_nettype none

package pps_pkg;

    localparam logic [1:0] KIND_TYPE3  = 2'd0;
    localparam logic [1:0] KIND_REGWR  = 2'd1;
    localparam logic [1:0] KIND_FILLER = 2'd2;
    localparam logic [1:0] KIND_BODY   = 2'd3;

    localparam logic [1:0] PKT_TYPE2 = 2'd2;
    localparam logic [1:0] PKT_TYPE3 = 2'd3;

    localparam logic [31:0] SENT_DEAD  = 32'hDEADBEEF;
    localparam logic [31:0] SENT_ONES  = 32'hFFFFFFFF;
    localparam logic [31:0] SENT_F8FF  = 32'hFFFFF8FF;
    localparam logic [31:0] SENT_SEVEN = 32'h77777777;
    localparam logic [31:0] SENT_ZERO  = 32'h00000000;

    localparam logic [6:0]  OPC_NOP       = 7'h7F;
    localparam logic [14:0] MAX_T3_COUNT  = 15'h4000;
    localparam logic [14:0] MAX_REG_COUNT = 15'd256;
    localparam logic [15:0] MAX_REG_BASE  = 16'hC000;
    localparam logic [31:0] WORD_BYTES    = 32'd4;

    typedef struct packed {
        logic [31:0] word;
        logic        first_in_range;
        logic        last_in_range;
        logic [31:0] range_base_addr;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  opcode;
        logic [14:0] length;
        logic        predicate;
        logic [15:0] first_reg;
        logic [31:0] value;
        logic [31:0] packet_addr;
        logic        last_of_packet;
        logic        truncated;
    } t_out_item;

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

`default_nettype wire

[rtl/pps_in_if.sv]
`default_nettype none

interface pps_in_if;
    logic              valid;
    logic              ready;
    pps_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/pps_out_if.sv]
`default_nettype none

interface pps_out_if;
    logic               valid;
    logic               ready;
    pps_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/pm4_packet_stream_parser.sv]
`default_nettype none
// An accepted word is held in the input register; its result is then registered in
// the output register. Throughput: one word per cycle while the sink is ready; the
// body counter and address update are computed combinationally from the input register.
// Both registers forward as soon as the next stage frees, so words stream without gaps.
// Reset (i_rst_n low, synchronous) empties both stages and clears the body count
// and both address registers to zero.
module pm4_packet_stream_parser (
    input  wire  i_clk,
    input  wire  i_rst_n,
    pps_in_if.sink    i_in,
    pps_out_if.source o_out
);
    import pps_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [14:0] r_words_left;
    logic [31:0] r_packet_addr;
    logic [31:0] r_next_addr;

    logic        advance;
    t_out_item   n_out;
    logic [14:0] n_words_left;
    logic [31:0] n_packet_addr;
    logic [31:0] n_next_addr;

    logic [31:0] w;
    logic [14:0] wl_cur;
    logic [31:0] addr;
    logic [14:0] cnt;
    logic        sentinel;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        w        = swap32(r_in.word);
        wl_cur   = r_in.first_in_range ? 15'd0 : r_words_left;
        addr     = r_in.first_in_range ? r_in.range_base_addr : r_next_addr;
        cnt      = {1'b0, w[29:16]} + 15'd1;
        sentinel = (w == SENT_DEAD) || (w == SENT_ONES) || (w == SENT_F8FF) ||
                   (w == SENT_SEVEN) || (w == SENT_ZERO);

        n_next_addr   = addr + WORD_BYTES;
        n_packet_addr = r_packet_addr;
        n_words_left  = wl_cur;

        n_out                = '0;
        n_out.kind           = KIND_FILLER;
        n_out.value          = w;
        n_out.last_of_packet = 1'b1;

        if (wl_cur != 15'd0) begin
            n_out.kind           = KIND_BODY;
            n_words_left         = wl_cur - 15'd1;
            n_out.last_of_packet = (n_words_left == 15'd0);
        end else begin
            n_packet_addr = addr;
            if (sentinel) begin
                n_out.kind = KIND_FILLER;
            end else if (w[31:30] == PKT_TYPE3) begin
                if (w[14:8] != OPC_NOP && cnt <= MAX_T3_COUNT) begin
                    n_out.kind           = KIND_TYPE3;
                    n_out.opcode         = w[14:8];
                    n_out.length         = cnt;
                    n_out.predicate      = w[0];
                    n_words_left         = cnt;
                    n_out.last_of_packet = 1'b0;
                end
            end else if (w[31:30] == PKT_TYPE2) begin
                n_out.kind = KIND_FILLER;
            end else begin
                if (cnt <= MAX_REG_COUNT && w[15:0] <= MAX_REG_BASE) begin
                    n_out.kind           = KIND_REGWR;
                    n_out.length         = cnt;
                    n_out.first_reg      = w[15:0];
                    n_words_left         = cnt;
                    n_out.last_of_packet = 1'b0;
                end
            end
        end

        if (r_in.last_in_range && n_words_left != 15'd0) begin
            n_out.truncated      = 1'b1;
            n_out.last_of_packet = 1'b1;
            n_words_left         = 15'd0;
        end

        n_out.packet_addr = n_packet_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_words_left  <= 15'd0;
            r_packet_addr <= 32'd0;
            r_next_addr   <= 32'd0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_words_left  <= n_words_left;
                r_packet_addr <= n_packet_addr;
                r_next_addr   <= n_next_addr;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_body_while_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.first_in_range && r_words_left != 15'd0
        |=> r_out.kind == KIND_BODY)
        else $error("word owed to a packet body was not reported as body");

    a_range_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_in_range |=> r_words_left == 15'd0)
        else $error("body count survived the end of a range");

    a_trunc_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.truncated |-> r_out.last_of_packet)
        else $error("truncated word does not close its packet");

    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.first_in_range |=> r_next_addr == $past(r_next_addr) + WORD_BYTES)
        else $error("word address did not advance by one word");

    a_open_packet_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_out.kind == KIND_TYPE3 || n_out.kind == KIND_REGWR)
        && !n_out.truncated |=> r_words_left == r_out.length)
        else $error("header length and body count disagree");

endmodule

`default_nettype wire

[dv/pps_parse_checker.sv]
`timescale 1ns / 100ps

module pps_parse_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    pps_in_if    i_in_mon,
    pps_out_if   i_out_mon,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_truncated
);
    import pps_pkg::*;

    t_out_item   owed_results[$];
    logic [14:0] body_left;
    logic [31:0] hdr_addr;
    logic [31:0] word_addr;
    int          mismatches;
    int          checked;
    int          truncated;

    function automatic t_out_item parse_word(input t_in_item it);
        t_out_item   r;
        logic [31:0] h;
        logic [31:0] addr;
        logic [14:0] cnt;
        logic [6:0]  op;
        h = {<<8{it.word}};
        r = '0;
        r.kind = KIND_FILLER;
        r.value = h;
        r.last_of_packet = 1'b1;
        if (it.first_in_range) begin
            body_left = '0;
            word_addr = it.range_base_addr;
        end
        addr = word_addr;
        word_addr = word_addr + WORD_BYTES;
        cnt = {1'b0, h[29:16]} + 15'd1;
        op = h[14:8];
        if (body_left != '0) begin
            r.kind = KIND_BODY;
            body_left = body_left - 15'd1;
            r.last_of_packet = (body_left == '0);
        end else begin
            hdr_addr = addr;
            if (h inside {SENT_DEAD, SENT_ONES, SENT_F8FF, SENT_SEVEN, SENT_ZERO}) begin
                r.kind = KIND_FILLER;
            end else if (h[31:30] == PKT_TYPE3) begin
                if (op != OPC_NOP && cnt <= MAX_T3_COUNT) begin
                    r.kind = KIND_TYPE3;
                    r.opcode = op;
                    r.length = cnt;
                    r.predicate = h[0];
                    body_left = cnt;
                    r.last_of_packet = 1'b0;
                end
            end else if (h[31:30] != PKT_TYPE2) begin
                if (cnt <= MAX_REG_COUNT && h[15:0] <= MAX_REG_BASE) begin
                    r.kind = KIND_REGWR;
                    r.length = cnt;
                    r.first_reg = h[15:0];
                    body_left = cnt;
                    r.last_of_packet = 1'b0;
                end
            end
        end
        if (it.last_in_range && body_left != '0) begin
            r.truncated = 1'b1;
            r.last_of_packet = 1'b1;
            body_left = '0;
        end
        r.packet_addr = hdr_addr;
        return r;
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf({"kind=%0d op=%h len=%0d pred=%0b first_reg=%h val=%h",
                          " addr=%h eop=%0b trunc=%0b"},
                         r.kind, r.opcode, r.length, r.predicate, r.first_reg, r.value,
                         r.packet_addr, r.last_of_packet, r.truncated);
    endfunction

    initial begin
        mismatches = 0;
        checked = 0;
        truncated = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            body_left = '0;
            hdr_addr = '0;
            word_addr = '0;
            owed_results.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: %s", $realtime, show(got));
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (want.truncated)
                        truncated++;
                    if (got.kind !== want.kind || got.opcode !== want.opcode ||
                        got.length !== want.length || got.predicate !== want.predicate ||
                        got.first_reg !== want.first_reg || got.value !== want.value ||
                        got.packet_addr !== want.packet_addr ||
                        got.last_of_packet !== want.last_of_packet ||
                        got.truncated !== want.truncated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                owed_results.insert(owed_results.size(), parse_word(i_in_mon.data));
        end
        o_errors <= mismatches;
        o_pending <= owed_results.size();
        o_checked <= checked;
        o_truncated <= truncated;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import pps_pkg::*;

    localparam int TOTAL_WORDS = 1550;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pps_in_if  in_ch ();
    pps_out_if out_ch ();

    int errors;
    int pending;
    int checked;
    int truncs;
    int words_sent = 0;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    logic [31:0] range_words[$];

    pm4_packet_stream_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pps_parse_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_truncated (truncs)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] t3_header(input logic [13:0] cf, input logic [6:0] op,
                                              input logic pred);
        return {PKT_TYPE3, cf, 1'b0, op, 7'h00, pred};
    endfunction

    function automatic logic [31:0] reg_header(input logic t, input logic [13:0] cf,
                                               input logic [15:0] base);
        return {1'b0, t, cf, base};
    endfunction

    // Builds a word as it sits in ring memory, so the header reads correctly once swapped.
    function automatic t_in_item ring_word(input logic [31:0] h, input logic first,
                                           input logic last, input logic [31:0] base);
        t_in_item it;
        it.word = {<<8{h}};
        it.first_in_range = first;
        it.last_in_range = last;
        it.range_base_addr = base;
        return it;
    endfunction

    task automatic send_word(input t_in_item it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    // Appends one packet to the range; returns 1 when its body was left incomplete.
    function automatic bit add_packet();
        int          sel;
        int          body;
        logic [13:0] cf;
        logic [15:0] rb;
        logic [31:0] h;
        sel = $urandom_range(99);
        body = 0;
        cf = ($urandom_range(19) == 0) ? 14'($urandom()) : 14'($urandom_range(7));
        if (sel < 40) begin
            h = {PKT_TYPE3, cf, 1'($urandom()), 7'($urandom_range(126)), 7'($urandom()),
                 1'($urandom())};
            body = int'(cf) + 1;
        end else if (sel < 70) begin
            rb = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(49152));
            if ($urandom_range(9) == 0)
                cf = 14'($urandom_range(16383));
            h = {1'b0, 1'($urandom()), cf, rb};
            if (cf <= 14'd255 && rb <= MAX_REG_BASE)
                body = int'(cf) + 1;
        end else if (sel < 85) begin
            case ($urandom_range(6))
                0: h = SENT_DEAD;
                1: h = SENT_ONES;
                2: h = SENT_F8FF;
                3: h = SENT_SEVEN;
                4: h = SENT_ZERO;
                5: h = {PKT_TYPE2, 30'($urandom())};
                default: h = {PKT_TYPE3, cf, 1'($urandom()), OPC_NOP, 8'($urandom())};
            endcase
        end else begin
            h = {<<8{$urandom()}};
        end
        range_words.insert(range_words.size(), {<<8{h}});
        for (int i = 0; i < body && i < 48; i++)
            range_words.insert(range_words.size(), $urandom());
        return body > 48;
    endfunction

    task automatic send_range();
        t_in_item    it;
        int          cut;
        logic [31:0] base;
        bit          open;
        range_words.delete();
        open = 1'b0;
        repeat ($urandom_range(1, 6)) begin
            if (!open)
                open = add_packet();
        end
        case ($urandom_range(3))
            0: base = 32'h0;
            1: base = 32'hFFFFFFFC - 4 * $urandom_range(8);
            2: base = $urandom();
            default: base = $urandom() & 32'hFFFFFFFC;
        endcase
        cut = range_words.size() - 1;
        if ($urandom_range(4) == 0)
            cut = $urandom_range(cut);
        for (int i = 0; i <= cut; i++) begin
            it.word = range_words[i];
            it.first_in_range = (i == 0) && ($urandom_range(9) != 0);
            it.last_in_range = (i == cut) ? ($urandom_range(9) != 0)
                                          : ($urandom_range(49) == 0);
            it.range_base_addr = (i == 0) ? base : $urandom();
            send_word(it);
        end
    endtask

    initial begin
        int directed;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(ring_word(t3_header(14'h0, 7'h00, 1'b1), 1'b1, 1'b0, 32'hFFFFFFF8));
        send_word(ring_word(32'hFFFFFFFF, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(SENT_DEAD, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(SENT_ONES, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(SENT_F8FF, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(SENT_SEVEN, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(SENT_ZERO, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(t3_header(14'h5, OPC_NOP, 1'b1), 1'b0, 1'b0, 32'h0));
        send_word(ring_word({PKT_TYPE2, 30'h3FFFFFFF}, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(reg_header(1'b0, 14'd255, MAX_REG_BASE), 1'b0, 1'b0, 32'h0));
        send_word(ring_word(32'h12345678, 1'b0, 1'b1, 32'h0));
        send_word(ring_word(reg_header(1'b1, 14'd0, 16'hC001), 1'b1, 1'b0, 32'h0));
        send_word(ring_word(reg_header(1'b0, 14'd256, 16'h0000), 1'b0, 1'b0, 32'h0));
        send_word(ring_word(reg_header(1'b1, 14'd0, 16'h0000), 1'b0, 1'b0, 32'h0));
        send_word(ring_word(32'h0, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(t3_header(14'h3FFF, 7'h7E, 1'b0), 1'b0, 1'b0, 32'h0));
        send_word(ring_word(32'hA5A5A5A5, 1'b0, 1'b1, 32'h0));
        send_word(ring_word(t3_header(14'h0, 7'h01, 1'b1), 1'b1, 1'b1, 32'hFFFFFFFF));
        send_word(ring_word(reg_header(1'b0, 14'd1, 16'h0100), 1'b1, 1'b0, 32'h12345670));
        send_word(ring_word(32'hCAFEF00D, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(t3_header(14'd2, 7'h3C, 1'b0), 1'b1, 1'b0, 32'h00000100));
        send_word(ring_word(32'h00000001, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(32'h80000000, 1'b0, 1'b0, 32'h0));
        send_word(ring_word(32'h5A5A5A5A, 1'b0, 1'b1, 32'h0));
        send_word(ring_word(SENT_SEVEN, 1'b0, 1'b1, 32'h0));
        directed = words_sent;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            while (words_sent < directed + TOTAL_WORDS * (ph + 1) / 4)
                send_range();
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words in ranges of mixed packets under four handshake phases.",
                 words_sent);
        $display("Checked %0d results, %0d of them on truncated packets.", checked, truncs);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/pps_pkg.sv
rtl/pps_in_if.sv
rtl/pps_out_if.sv
rtl/pm4_packet_stream_parser.sv
dv/pps_parse_checker.sv
dv/testbench.sv
